// File: hdl/safr_pkg.sv
// ----------------------------------------------------------------------------
// safr_pkg
// Shared types and constants of the serial ADC frame reader.
// ----------------------------------------------------------------------------
package safr_pkg;

   localparam int unsigned SampleWidth  = 12;
   localparam int unsigned IndexWidth   = 4;
   localparam int unsigned ChannelWidth = 3;

   localparam logic [IndexWidth-1:0] FirstIndex        = 4'd15;
   localparam logic [IndexWidth-1:0] FirstChannelIndex = 4'd14;
   localparam logic [IndexWidth-1:0] LastCaptureIndex  = 4'd12;
   localparam logic [IndexWidth-1:0] LastIndex         = 4'd0;
   localparam logic [IndexWidth-1:0] FirstCaptureIndex = 4'd1;

   typedef enum logic [2:0] {
      PH_HIGH = 3'b001,
      PH_LOW  = 3'b010,
      PH_SEP  = 3'b100
   } phase_type;

   typedef struct packed {
      logic                   cs_n;
      logic                   sclk;
      logic                   mosi;
      logic                   ready_res;
      logic                   done_res;
      logic [SampleWidth-1:0] sample;
   } pins_type;

endpackage

// File: hdl/safr_core.sv
// ----------------------------------------------------------------------------
// safr_core
// Frame sequencer: tick state, channel shift-out and sample shift-in.
// ----------------------------------------------------------------------------
module safr_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step_en,
   input  logic                                 start_req,
   input  logic [safr_pkg::ChannelWidth-1:0]    channel,
   input  logic                                 miso,
   output safr_pkg::pins_type                   pins
);
   import safr_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    frame_pass_ff, frame_pass_in;
   logic [IndexWidth-1:0]   clock_index_ff, clock_index_in;
   phase_type               phase_ff, phase_in;
   logic [SampleWidth-1:0]  shift_ff, shift_in;
   logic [ChannelWidth-1:0] held_channel_ff, held_channel_in;
   logic                    capture_ff, capture_in;
   logic [SampleWidth-1:0]  shift_cap;

   always_comb begin
      shift_cap       = capture_ff ? {shift_ff[SampleWidth-2:0], miso} : shift_ff;
      busy_in         = busy_ff;
      frame_pass_in   = frame_pass_ff;
      clock_index_in  = clock_index_ff;
      phase_in        = phase_ff;
      shift_in        = shift_cap;
      held_channel_in = held_channel_ff;
      capture_in      = 1'b0;
      pins            = '{cs_n: 1'b1, sclk: 1'b0, mosi: 1'b0, ready_res: 1'b0,
                          done_res: 1'b0, sample: '0};
      if (!busy_ff) begin
         pins.ready_res = 1'b1;
         if (start_req) begin
            busy_in         = 1'b1;
            frame_pass_in   = 1'b0;
            held_channel_in = channel;
            clock_index_in  = FirstIndex;
            phase_in        = PH_HIGH;
            shift_in        = '0;
         end
      end else begin
         unique case (phase_ff)
            PH_HIGH: begin
               pins.cs_n = 1'b0;
               pins.sclk = 1'b1;
               if (clock_index_ff >= LastCaptureIndex &&
                   clock_index_ff <= FirstChannelIndex) begin
                  pins.mosi = held_channel_ff[clock_index_ff[1:0]];
               end
               phase_in = PH_LOW;
            end
            PH_LOW: begin
               pins.cs_n = 1'b0;
               capture_in = (clock_index_ff >= FirstCaptureIndex &&
                             clock_index_ff <= LastCaptureIndex);
               if (clock_index_ff == LastIndex) begin
                  phase_in = PH_SEP;
               end else begin
                  clock_index_in = clock_index_ff - 4'd1;
                  phase_in       = PH_HIGH;
               end
            end
            default: begin
               clock_index_in = FirstIndex;
               phase_in       = PH_HIGH;
               if (!frame_pass_ff) begin
                  frame_pass_in = 1'b1;
                  shift_in      = '0;
               end else begin
                  pins.done_res = 1'b1;
                  pins.sample   = shift_cap;
                  busy_in       = 1'b0;
                  frame_pass_in = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         frame_pass_ff   <= 1'b0;
         clock_index_ff  <= FirstIndex;
         phase_ff        <= PH_HIGH;
         shift_ff        <= '0;
         held_channel_ff <= '0;
         capture_ff      <= 1'b0;
      end else if (step_en) begin
         busy_ff         <= busy_in;
         frame_pass_ff   <= frame_pass_in;
         clock_index_ff  <= clock_index_in;
         phase_ff        <= phase_in;
         shift_ff        <= shift_in;
         held_channel_ff <= held_channel_in;
         capture_ff      <= capture_in;
      end
   end

endmodule

// File: hdl/spi_adc_frame_reader_top.sv
// ----------------------------------------------------------------------------
// spi_adc_frame_reader_top
// Tick-level serial master for a 12-bit ADC: two frames per conversion,
// channel sent on clocks 2 to 4 of each frame, sample taken from frame two.
// ----------------------------------------------------------------------------
//   port group | direction | carries
//   req_*      | in        | one tick: start_req, channel, miso
//   rsp_*      | out       | pin levels, ready_res, done_res, sample
//
// One item per cycle sustained while the result side is not stalled.
// Input register feeds the sequencer, result register holds its outputs.
// A held result stalls the input side only when the input register is full.
// Reset is synchronous and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module spi_adc_frame_reader_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_start_req,
   input  logic [safr_pkg::ChannelWidth-1:0]    req_channel,
   input  logic                                 req_miso,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_cs_n,
   output logic                                 rsp_sclk,
   output logic                                 rsp_mosi,
   output logic                                 rsp_ready_res,
   output logic                                 rsp_done_res,
   output logic [safr_pkg::SampleWidth-1:0]     rsp_sample
);
   import safr_pkg::*;

   logic                    in_valid_ff;
   logic                    in_start_ff;
   logic [ChannelWidth-1:0] in_channel_ff;
   logic                    in_miso_ff;
   logic                    out_valid_ff;
   pins_type                out_pins_ff;
   pins_type                pins_in;
   logic                    out_free;
   logic                    step_en;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   safr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .start_req (in_start_ff),
      .channel   (in_channel_ff),
      .miso      (in_miso_ff),
      .pins      (pins_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= step_en;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_start_ff   <= req_start_req;
         in_channel_ff <= req_channel;
         in_miso_ff    <= req_miso;
      end
      if (step_en) begin
         out_pins_ff <= pins_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_cs_n      = out_pins_ff.cs_n;
   assign rsp_sclk      = out_pins_ff.sclk;
   assign rsp_mosi      = out_pins_ff.mosi;
   assign rsp_ready_res = out_pins_ff.ready_res;
   assign rsp_done_res  = out_pins_ff.done_res;
   assign rsp_sample    = out_pins_ff.sample;

   a_sclk_in_frame : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sclk |-> !rsp_cs_n)
      else $error("sclk high outside a frame");

   a_mosi_on_high : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mosi |-> rsp_sclk)
      else $error("mosi driven outside a high tick");

   a_done_idle_pins : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_cs_n && !rsp_sclk && !rsp_ready_res)
      else $error("done with frame pins active or ready");

   a_sample_only_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_sample == '0)
      else $error("sample nonzero without done");

   a_no_loss : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && req_stall |=> in_valid_ff)
      else $error("stalled input item dropped");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Tick-level check of the serial ADC frame reader. A short table of
// directed ticks runs one full conversion with typed pin levels at the
// points that are easy to read off. After it come random conversions with
// patterned or random data-out, idle noise and start requests while busy.
// Every untyped tick's pin levels are compared with an in-bench model of the
// sequencer, while both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import safr_pkg::*;

   typedef enum int unsigned {
      MISO_RANDOM,
      MISO_LOW,
      MISO_HIGH,
      MISO_SPLIT
   } miso_pattern_type;

   typedef struct packed {
      logic                    start;
      logic [ChannelWidth-1:0] chan;
      logic                    miso;
      logic [7:0]              span;
      logic                    typed;
      pins_type                want;
   } tick_row_type;

   localparam pins_type IdlePins = '{cs_n: 1'b1, sclk: 1'b0, mosi: 1'b0,
                                     ready_res: 1'b1, done_res: 1'b0, sample: '0};
   localparam pins_type FirstHighPins = '{cs_n: 1'b0, sclk: 1'b1, mosi: 1'b0,
                                          ready_res: 1'b0, done_res: 1'b0, sample: '0};
   localparam pins_type FullScalePins = '{cs_n: 1'b1, sclk: 1'b0, mosi: 1'b0,
                                          ready_res: 1'b0, done_res: 1'b1,
                                          sample: 12'hFFF};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_start_req = 1'b0;
   logic [ChannelWidth-1:0] req_channel = '0;
   logic                    req_miso = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_cs_n;
   logic                    rsp_sclk;
   logic                    rsp_mosi;
   logic                    rsp_ready_res;
   logic                    rsp_done_res;
   logic [SampleWidth-1:0]  rsp_sample;

   pins_type       expected_pins[$];
   int unsigned    fail_count = 0;
   bit             steady = 1'b0;

   logic                    conv_busy = 1'b0;
   logic                    second_frame = 1'b0;
   logic [IndexWidth-1:0]   clk_idx = FirstIndex;
   phase_type               tick_phase = PH_HIGH;
   logic [SampleWidth-1:0]  acc = '0;
   logic [ChannelWidth-1:0] latched_ch = '0;
   logic                    capture_armed = 1'b0;

   tick_row_type script[8];

   spi_adc_frame_reader_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_start_req (req_start_req),
      .req_channel   (req_channel),
      .req_miso      (req_miso),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cs_n      (rsp_cs_n),
      .rsp_sclk      (rsp_sclk),
      .rsp_mosi      (rsp_mosi),
      .rsp_ready_res (rsp_ready_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_sample    (rsp_sample)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 20);
   endfunction

   function automatic void open_frame();
      clk_idx    = FirstIndex;
      tick_phase = PH_HIGH;
      acc        = '0;
   endfunction

   function automatic pins_type step_converter(input logic s,
                                               input logic [ChannelWidth-1:0] c,
                                               input logic m);
      pins_type p;
      p      = '0;
      p.cs_n = 1'b1;
      if (capture_armed) begin
         acc           = {acc[SampleWidth-2:0], m};
         capture_armed = 1'b0;
      end
      if (!conv_busy) begin
         p.ready_res = 1'b1;
         if (s) begin
            conv_busy    = 1'b1;
            second_frame = 1'b0;
            latched_ch   = c;
            open_frame();
         end
      end else begin
         case (tick_phase)
            PH_HIGH: begin
               p.cs_n = 1'b0;
               p.sclk = 1'b1;
               if (clk_idx >= LastCaptureIndex && clk_idx <= FirstChannelIndex) begin
                  p.mosi = latched_ch[2'(clk_idx - LastCaptureIndex)];
               end
               tick_phase = PH_LOW;
            end
            PH_LOW: begin
               p.cs_n = 1'b0;
               if (clk_idx >= FirstCaptureIndex && clk_idx <= LastCaptureIndex) begin
                  capture_armed = 1'b1;
               end
               if (clk_idx == LastIndex) begin
                  tick_phase = PH_SEP;
               end else begin
                  clk_idx    = clk_idx - 4'd1;
                  tick_phase = PH_HIGH;
               end
            end
            default: begin
               if (!second_frame) begin
                  second_frame = 1'b1;
                  open_frame();
               end else begin
                  p.done_res   = 1'b1;
                  p.sample     = acc;
                  conv_busy    = 1'b0;
                  second_frame = 1'b0;
                  clk_idx      = FirstIndex;
                  tick_phase   = PH_HIGH;
               end
            end
         endcase
      end
      return p;
   endfunction

   task automatic apply_tick(input logic s, input logic [ChannelWidth-1:0] c,
                             input logic m, input logic typed, input pins_type want);
      int unsigned gap;
      pins_type    predicted;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_start_req <= s;
      req_channel   <= c;
      req_miso      <= m;
      do @(posedge clock); while (req_stall);
      predicted = step_converter(s, c, m);
      expected_pins.push_back(typed ? want : predicted);
   endtask

   task automatic check_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      pins_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pins.size() == 0) begin
            $error("result item with no item pending");
            fail_count++;
         end else begin
            want = expected_pins.pop_front();
            check_field("cs_n", 32'(want.cs_n), 32'(rsp_cs_n));
            check_field("sclk", 32'(want.sclk), 32'(rsp_sclk));
            check_field("mosi", 32'(want.mosi), 32'(rsp_mosi));
            check_field("ready_res", 32'(want.ready_res), 32'(rsp_ready_res));
            check_field("done_res", 32'(want.done_res), 32'(rsp_done_res));
            check_field("sample", 32'(want.sample), 32'(rsp_sample));
         end
      end
   end

   initial begin
      int unsigned n;
      @(posedge clock);
      forever begin
         n = pick_gap();
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   initial begin
      #(5_000_000);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int unsigned             items;
      int unsigned             waited;
      miso_pattern_type        pattern;
      logic                    s;
      logic [ChannelWidth-1:0] c;
      logic                    m;

      items       = 0;
      pattern     = MISO_RANDOM;

      // idle, accept on channel 7, ignored starts, frame two all ones
      script = '{
         '{1'b0, 3'd0, 1'b0, 8'd3,  1'b1, IdlePins},
         '{1'b0, 3'd7, 1'b1, 8'd1,  1'b1, IdlePins},
         '{1'b1, 3'd7, 1'b0, 8'd1,  1'b1, IdlePins},
         '{1'b1, 3'd0, 1'b0, 8'd1,  1'b1, FirstHighPins},
         '{1'b1, 3'd0, 1'b0, 8'd32, 1'b0, '0},
         '{1'b1, 3'd5, 1'b1, 8'd32, 1'b0, '0},
         '{1'b0, 3'd0, 1'b0, 8'd1,  1'b1, FullScalePins},
         '{1'b0, 3'd2, 1'b1, 8'd2,  1'b1, IdlePins}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r]) begin
         for (int k = 0; k < script[r].span; k++) begin
            apply_tick(script[r].start, script[r].chan, script[r].miso,
                       script[r].typed, script[r].want);
         end
      end

      while (items < 1500) begin
         if (!conv_busy) begin
            s = ($urandom_range(0, 3) == 0);
            c = ChannelWidth'($urandom);
            m = 1'($urandom);
            if (s) begin
               pattern = miso_pattern_type'($urandom_range(0, 3));
            end
         end else begin
            s = 1'($urandom);
            c = ChannelWidth'($urandom);
            case (pattern)
               MISO_LOW:   m = 1'b0;
               MISO_HIGH:  m = 1'b1;
               MISO_SPLIT: m = !second_frame;
               default:    m = 1'($urandom);
            endcase
         end
         apply_tick(s, c, m, 1'b0, '0);
         items++;
         if (items % 128 == 0) begin
            steady = ($urandom_range(0, 3) == 0);
         end
      end

      req_valid <= 1'b0;
      waited = 0;
      while (expected_pins.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (expected_pins.size() != 0) begin
         $error("%0d result items never arrived", expected_pins.size());
         fail_count++;
      end

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: spi_adc_frame_reader_top.f
hdl/safr_pkg.sv
hdl/safr_core.sv
hdl/spi_adc_frame_reader_top.sv
verif/tb.sv
